// File: design/cdq_pkg.sv
// cdq_pkg: shared types and constants for the circular deque.
// Request and status codes, the classified command word, back-end states.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int WORD_W = 32;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_LEFT  = 2'd0,
    REQ_INS_RIGHT = 2'd1,
    REQ_REM_LEFT  = 2'd2,
    REQ_REM_RIGHT = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef struct packed {
    logic                     insert;
    logic                     at_left;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } b_state_t;

endpackage

// File: design/cdq_front.sv
// cdq_front: accepts request words, classifies them into commands and
// holds them in a two-entry queue for the back end.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_front
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     q_valid,
  output cmd_t                     q_cmd,
  input  logic                     q_pop
);

  cmd_t       entries_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.value = in_value;
    case (req_t'(in_req_type))
      REQ_INS_LEFT: begin
        cmd_in.insert  = 1'b1;
        cmd_in.at_left = 1'b1;
      end
      REQ_INS_RIGHT: begin
        cmd_in.insert  = 1'b1;
        cmd_in.at_left = 1'b0;
      end
      REQ_REM_LEFT: begin
        cmd_in.insert  = 1'b0;
        cmd_in.at_left = 1'b1;
      end
      default: begin
        cmd_in.insert  = 1'b0;
        cmd_in.at_left = 1'b0;
      end
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = entries_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = q_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_r] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("front queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0)
    else $error("pop from empty front queue");

  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("front queue lost a word");
`endif

endmodule

// File: design/cdq_back.sv
// cdq_back: executes deque commands against the circular store, keeps the
// end pointers and the fill count, and drives the registered result.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_back
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  cmd_t                     q_cmd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_removed,
  output logic [OCC_W-1:0]         out_occupancy
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CW0 = $clog2(DEPTH + 1);
  localparam int CW  = (CW0 > OCC_W) ? CW0 : OCC_W;
  localparam logic [PW-1:0] LAST     = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  b_state_t                 state_r, state_nxt;
  logic [PW-1:0]            left_r, left_nxt;
  logic [PW-1:0]            right_r, right_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  status_r, status_nxt;
  logic signed [WORD_W-1:0] removed_r, removed_nxt;
  logic [OCC_W-1:0]         occ_r, occ_nxt;

  logic                     out_free;
  logic                     we, re;
  logic [PW-1:0]            waddr, raddr;
  logic [PW-1:0]            left_inc, left_dec, right_inc, right_dec;

  assign out_free  = !out_valid_r || !out_stall;
  assign left_inc  = (left_r == LAST) ? '0 : left_r + PW'(1);
  assign left_dec  = (left_r == '0) ? LAST : left_r - PW'(1);
  assign right_inc = (right_r == LAST) ? '0 : right_r + PW'(1);
  assign right_dec = (right_r == '0) ? LAST : right_r - PW'(1);

  always_comb begin
    state_nxt     = state_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    removed_nxt   = removed_r;
    occ_nxt       = occ_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = '0;
    raddr         = left_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_cmd.insert) begin
            out_valid_nxt = 1'b1;
            removed_nxt   = '0;
            if (count_r == FULL_CNT) begin
              status_nxt = ST_OVER;
              occ_nxt    = count_r[OCC_W-1:0];
            end else begin
              we = 1'b1;
              if (count_r == '0) begin
                left_nxt  = '0;
                right_nxt = '0;
                waddr     = '0;
              end else if (q_cmd.at_left) begin
                left_nxt = left_dec;
                waddr    = left_dec;
              end else begin
                right_nxt = right_inc;
                waddr     = right_inc;
              end
              count_nxt  = count_r + CW'(1);
              status_nxt = ST_DONE;
              occ_nxt    = count_nxt[OCC_W-1:0];
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_UNDER;
            removed_nxt   = '0;
            occ_nxt       = '0;
          end else begin
            re    = 1'b1;
            raddr = q_cmd.at_left ? left_r : right_r;
            if (left_r == right_r) begin
              left_nxt  = '0;
              right_nxt = '0;
            end else if (q_cmd.at_left) begin
              left_nxt = left_inc;
            end else begin
              right_nxt = right_dec;
            end
            count_nxt = count_r - CW'(1);
            state_nxt = B_READ;
          end
        end
      end
      B_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_DONE;
          removed_nxt   = rd_data_r;
          occ_nxt       = count_r[OCC_W-1:0];
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    occ_r     <= occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= q_cmd.value;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_removed   = removed_r;
  assign out_occupancy = occ_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (left_r == '0 && right_r == '0))
    else $error("pointers not home while empty");

  a_no_pop_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_READ) |-> !q_pop)
    else $error("command taken during pending read");

  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    re |=> (state_r == B_READ && !we))
    else $error("removal did not wait for read data");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(removed_r)))
    else $error("stalled result changed");
`endif

endmodule

// File: design/circular_deque.sv
// Double-ended queue of signed 32-bit words in a circular store of DEPTH.
// Channels: request in (in_req_type, in_value) and result out (out_status,
// out_removed, out_occupancy), each with valid/stall; a word moves on an edge
// with valid high and stall low. Every request gives exactly one result.
// in_req_type: 0 insert left, 1 insert right, 2 remove left, 3 remove right.
// out_status: 0 done, 1 overflow (insert when full), 2 underflow (removal
// when empty); out_removed is zero unless a removal succeeded.
// Throughput: one insert per cycle while out_stall stays low; a removal waits
// in B_READ for the registered store read, and the back end takes no new
// command until the removed word has been passed to the result register.
// A two-word queue separates the request side from the executing side, so
// requests are still taken, up to its two words, while a result waits on out_stall.
// Reset (rst_n low, synchronous) empties the deque, the front queue and the
// pending result; the store contents are not cleared and no clearing pass is needed.
// Depends on cdq_pkg, cdq_front, cdq_back.
`timescale 1ns / 1ps

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [WORD_W-1:0] out_removed,
  output logic [OCC_W-1:0]         out_occupancy
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  cdq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  cdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_removed   (out_removed),
    .out_occupancy (out_occupancy)
  );

endmodule

// File: dv/tb.sv
// tb: self-checking bench for circular_deque; directed table, then biased random traffic.
// Expected results come from the directed table or a deque predictor, checked in order.
// Depends on cdq_pkg and circular_deque.
`timescale 1ns / 1ps

module tb;
  import cdq_pkg::*;

  localparam int DEPTH    = 16;
  localparam int HOLD_LEN = 80;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] removed;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  typedef struct packed {
    req_t                     req;
    logic signed [WORD_W-1:0] value;
    logic                     typed;
    deque_result_t            result;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [REQ_W-1:0]         in_req_type;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_removed;
  logic [OCC_W-1:0]         out_occupancy;

  // predictor state
  logic signed [WORD_W-1:0] dq_store [DEPTH];
  int                       dq_left  = 0;
  int                       dq_right = 0;
  bit                       dq_empty = 1'b1;

  deque_result_t pending_results[$];
  int            err_count      = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            hold_req       = 0;
  int            hold_seen      = 0;
  int            hold_left      = 0;

  circular_deque #(.DEPTH(DEPTH)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_removed  (out_removed),
    .out_occupancy(out_occupancy)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int wrap_step(input int p, input int d);
    return (p + d + DEPTH) % DEPTH;
  endfunction

  function automatic deque_result_t deque_request(input req_t r,
                                                  input logic signed [WORD_W-1:0] v);
    deque_result_t res;
    bit            full;
    res.status  = ST_DONE;
    res.removed = '0;
    full = !dq_empty && wrap_step(dq_right, 1) == dq_left;
    if (r == REQ_INS_LEFT || r == REQ_INS_RIGHT) begin
      if (full) begin
        res.status = ST_OVER;
      end else if (dq_empty) begin
        dq_left     = 0;
        dq_right    = 0;
        dq_empty    = 1'b0;
        dq_store[0] = v;
      end else if (r == REQ_INS_LEFT) begin
        dq_left           = wrap_step(dq_left, -1);
        dq_store[dq_left] = v;
      end else begin
        dq_right           = wrap_step(dq_right, 1);
        dq_store[dq_right] = v;
      end
    end else if (dq_empty) begin
      res.status = ST_UNDER;
    end else begin
      res.removed = (r == REQ_REM_LEFT) ? dq_store[dq_left] : dq_store[dq_right];
      if (dq_left == dq_right) begin
        dq_empty = 1'b1;
        dq_left  = 0;
        dq_right = 0;
      end else if (r == REQ_REM_LEFT) begin
        dq_left = wrap_step(dq_left, 1);
      end else begin
        dq_right = wrap_step(dq_right, -1);
      end
    end
    res.occupancy = dq_empty ? '0 : OCC_W'(wrap_step(dq_right, -dq_left) + 1);
    return res;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input req_t r, input logic signed [WORD_W-1:0] v,
                           input logic typed, input deque_result_t typed_res);
    deque_result_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= r;
    in_value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = deque_request(r, v);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    deque_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request pending");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("out_status: expected %0d, got %0d", exp_r.status, out_status);
          err_count++;
        end
        if (out_removed !== exp_r.removed) begin
          $error("out_removed: expected %0d, got %0d", exp_r.removed, out_removed);
          err_count++;
        end
        if (out_occupancy !== exp_r.occupancy) begin
          $error("out_occupancy: expected %0d, got %0d", exp_r.occupancy, out_occupancy);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    dir_row_t dir_rows [26];
    int       fill_bias;
    bit       ins;
    bit       side;
    req_t     r;
    int       drain_wait;

    dir_rows = '{
      '{REQ_REM_LEFT,  32'sd0,           1'b1, '{ST_UNDER, 32'sd0, 5'd0}},
      '{REQ_REM_RIGHT, 32'sd0,           1'b1, '{ST_UNDER, 32'sd0, 5'd0}},
      '{REQ_INS_LEFT,  32'sh7fff_ffff,   1'b1, '{ST_DONE, 32'sd0, 5'd1}},
      '{REQ_REM_RIGHT, 32'sd0,           1'b1, '{ST_DONE, 32'sh7fff_ffff, 5'd0}},
      '{REQ_INS_RIGHT, 32'sh8000_0000,   1'b1, '{ST_DONE, 32'sd0, 5'd1}},
      '{REQ_INS_LEFT,  -32'sd1,          1'b1, '{ST_DONE, 32'sd0, 5'd2}},
      '{REQ_REM_LEFT,  32'sd0,           1'b1, '{ST_DONE, -32'sd1, 5'd1}},
      '{REQ_REM_LEFT,  32'sd0,           1'b1, '{ST_DONE, 32'sh8000_0000, 5'd0}},
      // fill to the brim from both ends
      '{REQ_INS_RIGHT, 32'sh0000_0001,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sh0000_0010,   1'b0, '0},
      '{REQ_INS_RIGHT, 32'sh0000_0100,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sh0000_1000,   1'b0, '0},
      '{REQ_INS_RIGHT, 32'sh0001_0000,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sh0010_0000,   1'b0, '0},
      '{REQ_INS_RIGHT, 32'sh0100_0000,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sh1000_0000,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sh5555_5555,   1'b0, '0},
      '{REQ_INS_LEFT,  32'shaaaa_aaaa,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sh0f0f_0f0f,   1'b0, '0},
      '{REQ_INS_RIGHT, 32'shf0f0_f0f0,   1'b0, '0},
      '{REQ_INS_RIGHT, 32'sh1234_5678,   1'b0, '0},
      '{REQ_INS_RIGHT, 32'sh8765_4321,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sh7fff_ffff,   1'b0, '0},
      '{REQ_INS_RIGHT, 32'sh8000_0000,   1'b0, '0},
      '{REQ_INS_LEFT,  32'sd99,          1'b1, '{ST_OVER, 32'sd0, 5'd16}},
      '{REQ_INS_RIGHT, -32'sd99,         1'b1, '{ST_OVER, 32'sd0, 5'd16}}
    };

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = '0;
    in_value    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 17;
    recv_stall_pct = 17;
    foreach (dir_rows[i])
      send_word(dir_rows[i].req, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].result);

    fill_bias = 50;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        3: begin send_idle_pct = 17; recv_stall_pct = 17; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 400; n++) begin
        // swing between filling, draining and mixed traffic to hit full and empty often
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0: fill_bias = 85;
            1: fill_bias = 15;
            default: fill_bias = 50;
          endcase
        end
        if (ph == 4 && n % 100 == 0)
          hold_req++;
        ins  = ($urandom_range(99) < fill_bias);
        side = $urandom_range(1);
        r = ins ? (side ? REQ_INS_RIGHT : REQ_INS_LEFT)
                : (side ? REQ_REM_RIGHT : REQ_REM_LEFT);
        send_word(r, pick_value(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (10) @(posedge clk);

    if (err_count == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
